@@ hw/rtl/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the keyframe window marginalizer: transaction
// payloads, configuration register indexes and arithmetic widths.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RATIO     = 2'd2;

  // register reset values
  localparam logic [2:0]  MAX_ACTIVE_RST     = 3'd7;
  localparam logic [31:0] FLOW_THRESHOLD_RST = 32'd655360;
  localparam logic [16:0] KEEP_RATIO_RST     = 17'd3277;

  // ratio of an empty slot, 1.0 in Q1.16
  localparam logic [16:0] RATIO_ONE = 17'h10000;

  // item modes
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_OFFER  = 1'b1;

  // arithmetic widths
  localparam int RAD_W   = 64;  // radicand of the root unit
  localparam int ROOT_W  = 32;  // root, also the norm in 2^-15 m
  localparam int DIVS_W  = 33;  // norm plus one
  localparam int QUOT_W  = 36;  // 2^35 / (norm + 1)
  localparam int SUM_W   = 40;  // sum of up to six reciprocal terms for eight slots
  localparam int SUM_LO_W = 20; // low half of the split score product
  localparam int D1_W    = 21;  // sqrt of the scaled norm
  localparam int SCORE_W = 64;
  localparam int D1_SHIFT = 9;

  typedef struct packed {
    logic               mode;
    logic [2:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        active_points;
    logic [15:0]        inactive_points;
    logic               is_fixed;
    logic [31:0]        flow_mean;
  } kwm_in_t;

  typedef struct packed {
    logic       added;
    logic       marg_valid;
    logic [2:0] marg_slot;
    logic       marg_by_ratio;
    logic [3:0] window_size;
  } kwm_out_t;

endpackage

@@ hw/rtl/kwm_isqrt.sv @@
// ----------------------------------------------------------------------------
// kwm_isqrt
// Iterative integer square root, floor(sqrt(rad)), two radicand bits per cycle.
// ----------------------------------------------------------------------------
module kwm_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kwm_pkg::RAD_W-1:0]   rad,
  output logic                        done,
  output logic [kwm_pkg::ROOT_W-1:0]  root
);
  import kwm_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  src;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;

  // one digit of the root per step
  always_comb begin
    shifted = {rem[REM_W-3:0], src[RAD_W-1:RAD_W-2]};
    trial   = {rem[REM_W-1:REM_W-2] & 2'b00, root[ROOT_W-1:0], 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        src  <= rad;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        src <= {src[RAD_W-3:0], 2'b00};
        if (shifted >= trial) begin
          rem  <= shifted - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/kwm_recip.sv @@
// ----------------------------------------------------------------------------
// kwm_recip
// Restoring divider for the reciprocal term 2^35 / divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module kwm_recip (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kwm_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [kwm_pkg::QUOT_W-1:0]  quot
);
  import kwm_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W:0]   shifted;
  logic              num_bit;

  // the numerator is a single one in its top bit
  always_comb begin
    num_bit = (cnt == '0);
    shifted = {rem, num_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem  <= DIVS_W'(shifted - {1'b0, dvs});
          quot <= {quot[QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= shifted[DIVS_W-1:0];
          quot <= {quot[QUOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/keyframe_window_marginalizer.sv @@
// ----------------------------------------------------------------------------
// keyframe_window_marginalizer
// Sliding window of keyframes with ratio and distance-score marginalization.
// ----------------------------------------------------------------------------
// A count update, a rejected offer and an offer that leaves the window within
// max_active are answered directly: the result strobes on done the cycle after
// start is taken. An offer that overfills the window runs a marginalization:
// the ratio scan reads, multiplies and compares each slot but the newest two,
// and the score search handles each slot pair in turn (memory read, three
// squares on one multiplier, then the shared 32-step square-root unit followed
// by either a second root or the 36-step reciprocal divider); the removal shift
// then moves each slot above the removed one down by one. No clearing pass
// follows reset. Results are strobed for one cycle and must be taken then;
// busy stays high until the marginalization is over.
// ----------------------------------------------------------------------------
module keyframe_window_marginalizer #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  kwm_pkg::kwm_in_t                     item,
  output logic                                 done,
  output kwm_pkg::kwm_out_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);
  import kwm_pkg::*;

  localparam int AW = $clog2(WINDOW_SLOTS);
  localparam int CW = $clog2(WINDOW_SLOTS + 1);
  localparam int XW = CW + 3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  typedef struct packed {
    logic [15:0] act;
    logic [15:0] inact;
  } cnt_t;

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_RAT_RD  = 22'h000002,
    S_RAT_MUL = 22'h000004,
    S_RAT_CMP = 22'h000008,
    S_K_RD    = 22'h000010,
    S_K_LD    = 22'h000020,
    S_N_RD    = 22'h000040,
    S_N_DIF   = 22'h000080,
    S_SQ      = 22'h000100,
    S_ACC     = 22'h000200,
    S_ROOT    = 22'h000400,
    S_ROOT_W  = 22'h000800,
    S_D1_W    = 22'h001000,
    S_DIV_W   = 22'h002000,
    S_NEXT_J  = 22'h004000,
    S_MUL0    = 22'h008000,
    S_MUL1    = 22'h010000,
    S_MUL2    = 22'h020000,
    S_CMP     = 22'h040000,
    S_SH_RD   = 22'h080000,
    S_SH_WR   = 22'h100000,
    S_FIX     = 22'h200000
  } state_t;

  state_t state;

  // configuration
  logic [2:0]  max_active;
  logic [31:0] flow_threshold;
  logic [16:0] keep_ratio;

  // window state
  pos_t                  pos_mem [WINDOW_SLOTS];
  cnt_t                  cnt_mem [WINDOW_SLOTS];
  pos_t                  pos_rd;
  cnt_t                  cnt_rd;
  logic [WINDOW_SLOTS-1:0] slot_fixed;
  logic [CW-1:0]         count;

  // memory port controls
  logic          pos_we;
  logic          cnt_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  pos_t          pos_wd;
  cnt_t          cnt_wd;

  // sequencer registers
  logic [AW-1:0] idx;
  logic [AW-1:0] k;
  logic [AW-1:0] j;
  logic [AW-1:0] sidx;
  logic [AW-1:0] mslot;
  logic          mvalid;
  logic          mratio;
  logic          d1_phase;
  logic [1:0]    sq_i;
  pos_t          kpos;
  logic [31:0]   dx, dy, dz;
  logic [63:0]   sq_prod;
  logic [63:0]   acc;
  logic [33:0]   ratio_prod;
  logic [31:0]   act_sh;
  logic          tot_zero;
  logic [D1_W-1:0]    d1;
  logic [SUM_W-1:0]   sum;
  logic [D1_W+SUM_LO_W-1:0]         p0;
  logic [D1_W+SUM_W-SUM_LO_W-1:0]   p1;
  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] best;

  // shared arithmetic units
  logic              sqrt_start;
  logic [RAD_W-1:0]  sqrt_rad;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  logic          accept;
  logic          slot_ok;
  logic          join_ok;
  logic [CW-1:0] count_inc;
  logic [AW-1:0] last;
  logic [31:0]   dsel;
  logic [16:0]   tot;

  kwm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  kwm_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor ({1'b0, sqrt_root} + DIVS_W'(1)),
    .done    (div_done),
    .quot    (div_quot)
  );

  // half of the absolute coordinate difference
  function automatic logic [31:0] half_abs(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? 33'(-d) : 33'(d);
    return m[32:1];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign count_inc = count + CW'(1);
  assign last      = AW'(count - CW'(1));
  assign slot_ok   = XW'(item.slot) < XW'(count);
  assign join_ok   = (item.is_fixed || (item.flow_mean > flow_threshold)) &&
                     (XW'(count) < XW'(WINDOW_SLOTS));
  assign tot       = {1'b0, cnt_rd.act} + {1'b0, cnt_rd.inact};

  // square operand select
  always_comb begin
    case (sq_i)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
  end

  // root and divider start requests
  always_comb begin
    sqrt_start = 1'b0;
    sqrt_rad   = acc;
    div_start  = 1'b0;
    if (state == S_ROOT) begin
      sqrt_start = 1'b1;
    end else if (state == S_ROOT_W && sqrt_done) begin
      if (d1_phase) begin
        sqrt_start = 1'b1;
        sqrt_rad   = {{(RAD_W-ROOT_W-D1_SHIFT){1'b0}}, sqrt_root, {D1_SHIFT{1'b0}}};
      end else begin
        div_start = 1'b1;
      end
    end
  end

  // memory port controls
  always_comb begin
    rd_addr = '0;
    pos_we  = 1'b0;
    cnt_we  = 1'b0;
    wr_addr = '0;
    pos_wd  = pos_rd;
    cnt_wd  = cnt_rd;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_wd = '{act: item.active_points, inact: item.inactive_points};
          pos_wd = '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
          if (item.mode == MODE_UPDATE) begin
            cnt_we  = slot_ok;
            wr_addr = AW'(item.slot);
          end else begin
            cnt_we  = join_ok;
            pos_we  = join_ok;
            wr_addr = AW'(count);
          end
        end
      end
      S_RAT_RD: rd_addr = idx;
      S_K_RD:   rd_addr = k;
      S_N_RD:   rd_addr = j;
      S_SH_RD:  rd_addr = AW'(sidx + 1'b1);
      S_SH_WR: begin
        pos_we  = 1'b1;
        cnt_we  = 1'b1;
        wr_addr = sidx;
      end
      default: ;
    endcase
  end

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    pos_rd <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
    cnt_rd <= cnt_mem[rd_addr];
  end

  // configuration write transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      max_active     <= MAX_ACTIVE_RST;
      flow_threshold <= FLOW_THRESHOLD_RST;
      keep_ratio     <= KEEP_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ACTIVE:     max_active     <= cfg_data[2:0];
        CFG_FLOW_THRESHOLD: flow_threshold <= cfg_data;
        CFG_KEEP_RATIO:     keep_ratio     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      count      <= '0;
      slot_fixed <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mvalid <= 1'b0;
            mratio <= 1'b0;
            mslot  <= '0;
            if (item.mode == MODE_OFFER && join_ok) begin
              slot_fixed[AW'(count)] <= item.is_fixed;
              count <= count_inc;
              if (XW'(count_inc) > XW'(max_active)) begin
                idx   <= '0;
                state <= S_RAT_RD;
              end else begin
                done   <= 1'b1;
                result <= '{added: 1'b1, marg_valid: 1'b0, marg_slot: 3'd0,
                            marg_by_ratio: 1'b0, window_size: 4'(count_inc)};
              end
            end else begin
              done   <= 1'b1;
              result <= '{added: 1'b0, marg_valid: 1'b0, marg_slot: 3'd0,
                          marg_by_ratio: 1'b0, window_size: 4'(count)};
            end
          end
        end

        // ratio scan over all slots but the newest two
        S_RAT_RD: begin
          if (XW'(idx) + XW'(2) < XW'(count)) begin
            state <= S_RAT_MUL;
          end else if (XW'(count) >= XW'(2)) begin
            k     <= '0;
            best  <= '0;
            mslot <= '0;
            state <= S_K_RD;
          end else begin
            state <= S_FIX;
          end
        end
        S_RAT_MUL: begin
          ratio_prod <= keep_ratio * tot;
          act_sh     <= {cnt_rd.act, 16'd0};
          tot_zero   <= (tot == '0);
          state      <= S_RAT_CMP;
        end
        S_RAT_CMP: begin
          if (tot_zero ? (keep_ratio > RATIO_ONE) : ({2'b00, act_sh} < ratio_prod)) begin
            mslot  <= idx;
            mratio <= 1'b1;
            sidx   <= idx;
            state  <= S_SH_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RAT_RD;
          end
        end

        // distance score of candidate k
        S_K_RD: state <= S_K_LD;
        S_K_LD: begin
          kpos     <= pos_rd;
          j        <= last;
          d1_phase <= 1'b1;
          state    <= S_N_RD;
        end
        S_N_RD: state <= S_N_DIF;
        S_N_DIF: begin
          dx    <= half_abs(kpos.x, pos_rd.x);
          dy    <= half_abs(kpos.y, pos_rd.y);
          dz    <= half_abs(kpos.z, pos_rd.z);
          sq_i  <= 2'd0;
          acc   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          sq_prod <= dsel * dsel;
          state   <= S_ACC;
        end
        S_ACC: begin
          acc  <= acc + sq_prod;
          sq_i <= sq_i + 1'b1;
          state <= (sq_i == 2'd2) ? S_ROOT : S_SQ;
        end
        S_ROOT: state <= S_ROOT_W;
        S_ROOT_W: begin
          if (sqrt_done) state <= d1_phase ? S_D1_W : S_DIV_W;
        end
        S_D1_W: begin
          if (sqrt_done) begin
            d1       <= sqrt_root[D1_W-1:0];
            d1_phase <= 1'b0;
            j        <= '0;
            sum      <= '0;
            state    <= S_NEXT_J;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            sum   <= sum + SUM_W'(div_quot);
            j     <= j + 1'b1;
            state <= S_NEXT_J;
          end
        end
        S_NEXT_J: begin
          if (j == last) begin
            state <= S_MUL0;
          end else if (j == k) begin
            j <= j + 1'b1;
          end else begin
            state <= S_N_RD;
          end
        end
        S_MUL0: begin
          p0    <= d1 * sum[SUM_LO_W-1:0];
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1    <= d1 * sum[SUM_W-1:SUM_LO_W];
          state <= S_MUL2;
        end
        S_MUL2: begin
          score <= SCORE_W'(p0) + SCORE_W'({p1, {SUM_LO_W{1'b0}}});
          state <= S_CMP;
        end
        S_CMP: begin
          if (score > best) begin
            best  <= score;
            mslot <= k;
          end
          if (AW'(k + 1'b1) == last) begin
            sidx  <= (score > best) ? k : mslot;
            state <= S_SH_RD;
          end else begin
            k     <= k + 1'b1;
            state <= S_K_RD;
          end
        end

        // removal: shift the slots above down by one
        S_SH_RD: begin
          if (XW'(sidx) + XW'(1) < XW'(count)) begin
            state <= S_SH_WR;
          end else begin
            count  <= count - CW'(1);
            mvalid <= 1'b1;
            state  <= S_FIX;
          end
        end
        S_SH_WR: begin
          slot_fixed[sidx] <= slot_fixed[AW'(sidx + 1'b1)];
          sidx  <= sidx + 1'b1;
          state <= S_SH_RD;
        end

        S_FIX: begin
          if (count > CW'(0)) slot_fixed[0] <= 1'b1;
          if (count > CW'(1)) slot_fixed[1] <= 1'b1;
          done   <= 1'b1;
          result <= '{added: 1'b1, marg_valid: mvalid, marg_slot: 3'(mslot),
                      marg_by_ratio: mratio, window_size: 4'(count)};
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/kwm_checker.sv @@
// ----------------------------------------------------------------------------
// kwm_port_checks
// Port-level checks of the keyframe window marginalizer, bound to the top.
// ----------------------------------------------------------------------------
module kwm_port_checks #(
  parameter int WINDOW_SLOTS = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input kwm_pkg::kwm_out_t             result
);
  import kwm_pkg::*;

  // an accepted transaction either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor in progress");

  // the window never reports more slots than it has
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.window_size <= 4'(WINDOW_SLOTS)))
    else $error("window size beyond slot count");

  // no removal means the removal fields read zero
  a_marg_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !result.marg_valid) |-> (result.marg_slot == 3'd0 && !result.marg_by_ratio))
    else $error("removal fields set without removal");

  // a removal only follows a frame that joined
  a_marg_added: assert property (@(posedge clk) disable iff (rst)
    (done && result.marg_valid) |-> result.added)
    else $error("removal without an added frame");

  // reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind keyframe_window_marginalizer kwm_port_checks #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_kwm_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result)
);
